>>> rtl/restricted_edit_distance_macros.svh
// assertion macros for the restricted edit distance block
`ifndef RESTRICTED_EDIT_DISTANCE_MACROS_SVH
`define RESTRICTED_EDIT_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
`define RTED_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define RTED_ASSERT(label, clk, rst_n, prop, msg)
`define RTED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/rted_pkg.sv
// shared types, constants and helpers of the restricted edit distance block
package rted_pkg;
    localparam int MAX_LEN     = 256;
    localparam int SYMBOL_BITS = 16;
    localparam int COST_BITS   = 10;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int ROW_DEPTH   = MAX_LEN + 1;

    typedef logic [SYMBOL_BITS-1:0] sym_t;
    typedef logic [COST_BITS-1:0]   cost_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    localparam cost_t COST_MAX = {COST_BITS{1'b1}};

    // operation mask bits
    localparam int OP_DEL = 0;
    localparam int OP_INS = 1;
    localparam int OP_SUB = 2;
    localparam int OP_TRA = 3;

    // configuration register indexes
    localparam logic REG_OPS = 1'b0;
    localparam logic REG_THR = 1'b1;

    // one classified item between front and back
    typedef struct packed {
        logic sel;
        logic has;
        logic last;
        sym_t sym;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    function automatic cost_t sat_len(len_t v);
        if (int'(v) > int'(COST_MAX))
            return COST_MAX;
        else
            return cost_t'(v);
    endfunction

    function automatic cost_t inc_cost(cost_t v);
        if (v == COST_MAX)
            return COST_MAX;
        else
            return v + cost_t'(1);
    endfunction
endpackage

>>> rtl/rted_front.sv
// input stage: takes stream transfers and keeps those that carry work
module rted_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 push,
    output rted_pkg::item_t      push_item,
    input  rted_pkg::q_status_t  q_status
);
    import rted_pkg::*;

    logic  entry_valid_reg, entry_valid_next;
    item_t entry_reg;
    logic  accept;
    logic  keep;

    assign s_tready  = !entry_valid_reg || !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign keep      = s_tuser[1] || s_tlast;
    assign push      = entry_valid_reg && !q_status.full;
    assign push_item = entry_reg;

    // items with no symbol and no end mark carry no work
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (accept)
            entry_valid_next = keep;
        else if (push)
            entry_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else
            entry_valid_reg <= entry_valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.sel  <= s_tuser[0];
            entry_reg.has  <= s_tuser[1];
            entry_reg.last <= s_tlast;
            entry_reg.sym  <= s_tdata[SYMBOL_BITS-1:0];
        end
    end
endmodule

>>> rtl/rted_queue.sv
// two-entry queue between front and back
module rted_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rted_pkg::item_t      push_item,
    input  logic                 pop,
    output rted_pkg::item_t      head,
    output rted_pkg::q_status_t  status
);
    import rted_pkg::*;

    item_t      entries [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head         = entries[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_item;
    end
endmodule

>>> rtl/rted_back.sv
// string stores and the cell-serial cost sweep
module rted_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rted_pkg::item_t        head,
    input  rted_pkg::q_status_t    q_status,
    output logic                   pop,
    input  logic [3:0]             enabled_ops,
    output logic                   res_valid,
    input  logic                   res_taken,
    output rted_pkg::cost_t        res_distance,
    output logic                   res_too_long,
    output rted_pkg::back_status_t status
);
    import rted_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_START  = 5'b00010,
        S_ROW    = 5'b00100,
        S_ROWCAP = 5'b01000,
        S_RD     = 5'b10000
    } state_t;
    // cell write phase is tracked by its own flag
    state_t state_reg, state_next;
    logic   wr_phase_reg, wr_phase_next;

    sym_t  first_mem  [MAX_LEN];
    sym_t  second_mem [MAX_LEN];
    sym_t  first_rd_reg, second_rd_reg;
    cost_t row_mem [3][ROW_DEPTH];
    cost_t rd_reg  [3];

    len_t  first_len_reg, second_len_reg;
    logic  ovf_reg;
    len_t  i_reg, j_reg, n_reg, m_reg;
    logic  row_sec_reg;
    logic [1:0] cur_sel_reg, one_sel_reg, two_sel_reg;
    cost_t left_reg, diag_reg;
    sym_t  r_cur_reg, r_prev_reg, c_prev_reg;
    logic  res_valid_reg;
    cost_t res_distance_reg;
    logic  res_too_long_reg;

    addr_t row_addr, col_addr, first_raddr, second_raddr;
    len_t  j_minus2;
    len_t  cost_raddr [3];
    logic  cost_we;
    len_t  cost_waddr;
    cost_t cost_wdata;
    sym_t  row_rd, col_rd;
    cost_t one_val, two_val, best, cell_cost;
    logic  match, tra_ok;
    logic  append, start_sweep, row_end, last_row;

    assign res_valid    = res_valid_reg;
    assign res_distance = res_distance_reg;
    assign res_too_long = res_too_long_reg;
    assign status.busy  = (state_reg != S_IDLE);

    // take an item when idle, unless it ends a pair while the last result still waits
    assign pop = (state_reg == S_IDLE) && !q_status.empty &&
                 !(head.last && res_valid_reg);
    assign append      = pop && head.has;
    assign start_sweep = pop && head.last;

    // read addresses follow the row and column roles of the two stores
    assign row_addr     = addr_t'(i_reg - len_t'(1));
    assign col_addr     = addr_t'(j_reg - len_t'(1));
    assign first_raddr  = row_sec_reg ? col_addr : row_addr;
    assign second_raddr = row_sec_reg ? row_addr : col_addr;
    assign row_rd       = row_sec_reg ? second_rd_reg : first_rd_reg;
    assign col_rd       = row_sec_reg ? first_rd_reg : second_rd_reg;

    // string stores
    always_ff @(posedge clk)
    begin
        if (append && !head.sel && int'(first_len_reg) < MAX_LEN)
            first_mem[addr_t'(first_len_reg)] <= head.sym;
        if (append && head.sel && int'(second_len_reg) < MAX_LEN)
            second_mem[addr_t'(second_len_reg)] <= head.sym;
        first_rd_reg  <= first_mem[first_raddr];
        second_rd_reg <= second_mem[second_raddr];
    end

    // cost row banks: previous row at j, the row before at j-2
    assign j_minus2 = j_reg - len_t'(2);
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cost_raddr[k] = (one_sel_reg == 2'(k)) ? j_reg : j_minus2;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cost_we && cur_sel_reg == 2'(k))
                row_mem[k][cost_waddr] <= cost_wdata;
            rd_reg[k] <= row_mem[k][cost_raddr[k]];
        end
    end

    // cell evaluation; the start row is implied by the index
    always_comb
    begin
        one_val = (i_reg == '0) ? sat_len(j_reg) : rd_reg[one_sel_reg];
        two_val = (i_reg == len_t'(1)) ? sat_len(j_minus2) : rd_reg[two_sel_reg];
        match   = (i_reg != '0) && (r_cur_reg == col_rd);
        tra_ok  = enabled_ops[OP_TRA] && (i_reg > len_t'(1)) && (j_reg > len_t'(1)) &&
                  (r_cur_reg == c_prev_reg) && (r_prev_reg == col_rd);
        best = COST_MAX;
        if (enabled_ops[OP_DEL] && inc_cost(one_val) < best)
            best = inc_cost(one_val);
        if (enabled_ops[OP_INS] && inc_cost(left_reg) < best)
            best = inc_cost(left_reg);
        if (enabled_ops[OP_SUB] && inc_cost(diag_reg) < best)
            best = inc_cost(diag_reg);
        if (tra_ok && inc_cost(two_val) < best)
            best = inc_cost(two_val);
        cell_cost = match ? diag_reg : best;
    end

    // bank write port
    always_comb
    begin
        cost_we    = 1'b0;
        cost_waddr = j_reg;
        cost_wdata = cell_cost;
        if (state_reg == S_ROW)
        begin
            cost_we    = 1'b1;
            cost_waddr = '0;
            cost_wdata = sat_len(i_reg);
        end
        else if (wr_phase_reg)
            cost_we = 1'b1;
    end

    assign last_row = (i_reg == n_reg);
    assign row_end  = ((state_reg == S_ROWCAP) && (m_reg == '0)) ||
                      (wr_phase_reg && (j_reg == m_reg));

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        wr_phase_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (start_sweep)
                    state_next = S_START;
            S_START:
                state_next = S_ROW;
            S_ROW:
                state_next = S_ROWCAP;
            S_ROWCAP:
                if (m_reg == '0)
                    state_next = last_row ? S_IDLE : S_ROW;
                else
                    state_next = S_RD;
            S_RD:
                if (!wr_phase_reg)
                    wr_phase_next = 1'b1;
                else if (j_reg == m_reg)
                    state_next = last_row ? S_IDLE : S_ROW;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wr_phase_reg     <= 1'b0;
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            ovf_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_phase_reg <= wr_phase_next;
            // appends
            if (append)
            begin
                if (!head.sel && int'(first_len_reg) < MAX_LEN)
                    first_len_reg <= first_len_reg + len_t'(1);
                else if (head.sel && int'(second_len_reg) < MAX_LEN)
                    second_len_reg <= second_len_reg + len_t'(1);
                else
                    ovf_reg <= 1'b1;
            end
            // result handoff
            if (res_taken)
                res_valid_reg <= 1'b0;
            if (row_end && last_row)
            begin
                res_valid_reg  <= 1'b1;
                first_len_reg  <= '0;
                second_len_reg <= '0;
                ovf_reg        <= 1'b0;
            end
        end
    end

    // sweep datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_START:
            begin
                row_sec_reg <= (second_len_reg < first_len_reg);
                n_reg <= (second_len_reg < first_len_reg) ? second_len_reg : first_len_reg;
                m_reg <= (second_len_reg < first_len_reg) ? first_len_reg : second_len_reg;
                i_reg       <= '0;
                cur_sel_reg <= 2'd0;
                one_sel_reg <= 2'd1;
                two_sel_reg <= 2'd2;
            end
            S_ROW:
            begin
                left_reg <= sat_len(i_reg);
                diag_reg <= (i_reg == '0) ? '0 : sat_len(i_reg - len_t'(1));
                j_reg    <= len_t'(1);
            end
            S_ROWCAP:
            begin
                r_prev_reg <= r_cur_reg;
                r_cur_reg  <= row_rd;
            end
            S_RD:
                if (wr_phase_reg)
                begin
                    left_reg   <= cell_cost;
                    diag_reg   <= one_val;
                    c_prev_reg <= col_rd;
                    if (j_reg != m_reg)
                        j_reg <= j_reg + len_t'(1);
                end
            default:
            begin
            end
        endcase
        // next row rotates the banks
        if (row_end && !last_row)
        begin
            i_reg       <= i_reg + len_t'(1);
            cur_sel_reg <= two_sel_reg;
            one_sel_reg <= cur_sel_reg;
            two_sel_reg <= one_sel_reg;
        end
        if (row_end && last_row)
        begin
            res_distance_reg <= wr_phase_reg ? cell_cost : left_reg;
            res_too_long_reg <= ovf_reg;
        end
    end
endmodule

>>> rtl/restricted_edit_distance.sv
// top level of the restricted edit distance block
//
// Input stream (s_*): each transfer carries one symbol in tdata, its string
// (tuser bit 0) and a symbol-present flag (tuser bit 1); tlast closes the
// pair and starts the distance computation. Result stream (m_*): one transfer
// per closed pair with distance, within_threshold and too_long.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 enabled operations mask, 1 close threshold).
// Symbol transfers are taken one per cycle through a two-entry queue while
// it is not full; the back end appends one symbol per cycle while idle. A
// closed pair with row length n and column length m (n <= m) is swept by
// the single cell unit, which needs a read and a write step per cell.
// Symbols of the next pair queue up meanwhile until the queue is full.
// Reset clears lengths, flags, queue and result; the string stores and cost
// rows need no clearing. A stalled result holds in its output register; the
// next pair may load, but its sweep waits until the result is taken.
module restricted_edit_distance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // symbol
    input  logic [1:0]  s_tuser,   // string_id, has_symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // distance, within_threshold, too_long, zero fill
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);
    import rted_pkg::*;

`include "restricted_edit_distance_macros.svh"

    logic         [3:0] ops_reg;
    logic         [9:0] thr_reg;
    logic               q_push, q_pop;
    item_t              push_item, head;
    q_status_t          q_status;
    back_status_t       back_status;
    cost_t              res_distance;
    logic               res_too_long;
    logic               close_flag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ops_reg <= 4'd15;
            thr_reg <= 10'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OPS: ops_reg <= cfg_wdata[3:0];
                REG_THR: thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rted_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .push      (q_push),
        .push_item (push_item),
        .q_status  (q_status)
    );

    rted_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .status    (q_status)
    );

    rted_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (q_pop),
        .enabled_ops  (ops_reg),
        .res_valid    (m_tvalid),
        .res_taken    (m_tready),
        .res_distance (res_distance),
        .res_too_long (res_too_long),
        .status       (back_status)
    );

    // result packing
    assign close_flag = (res_distance <= thr_reg);
    assign m_tdata    = {4'd0, res_too_long, close_flag, 10'(res_distance)};

    `RTED_ASSERT(a_push_room, clk, rst_n, q_push |-> !q_status.full, "push into full queue")
    `RTED_ASSERT(a_pop_data, clk, rst_n, q_pop |-> !q_status.empty, "pop from empty queue")
    `RTED_ASSERT(a_result_src, clk, rst_n, $rose(m_tvalid) |-> $past(back_status.busy), "result without sweep")
    `RTED_ASSERT_NEXT(a_sweep_start, clk, rst_n, q_pop && head.last, back_status.busy, "end item did not start sweep")
endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the restricted edit distance block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rted_pkg::*;

    typedef struct packed {
        logic        sel;
        logic        has;
        logic        last;
        logic [15:0] sym;
    } pair_item_t;

    typedef struct packed {
        logic [9:0] distance;
        logic       close;
        logic       ovf;
    } dist_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_wdata;

    // predictor state
    logic [15:0] str_a [MAX_LEN];
    logic [15:0] str_b [MAX_LEN];
    int          len_a = 0;
    int          len_b = 0;
    logic        ovf_seen = 1'b0;
    logic [3:0]  ops_mask;
    logic [9:0]  close_limit;

    pair_item_t   pending_items[$];
    dist_result_t expected_dists[$];
    int           queued_count = 0;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           error_count = 0;
    int           cycle_count = 0;
    logic         hold_sender;

    restricted_edit_distance u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [9:0] bump(logic [9:0] v);
        return (v == COST_MAX) ? COST_MAX : v + 10'd1;
    endfunction

    function automatic logic [9:0] clip(int v);
        return (v > int'(COST_MAX)) ? COST_MAX : v[9:0];
    endfunction

    // osa distance, row string r of length n, column string c of length m
    function automatic logic [9:0] osa_distance(logic [15:0] r[], logic [15:0] c[]);
        logic [9:0] two [];
        logic [9:0] one [];
        logic [9:0] cur [];
        logic [9:0] best;
        int n;
        int m;
        n = r.size();
        m = c.size();
        two = new[m + 1];
        one = new[m + 1];
        cur = new[m + 1];
        for (int j = 0; j <= m; j++)
            cur[j] = clip(j);
        for (int i = 0; i <= n; i++)
        begin
            two = one;
            one = cur;
            cur = new[m + 1];
            cur[0] = clip(i);
            for (int j = 1; j <= m; j++)
            begin
                if (i >= 1 && r[i-1] == c[j-1])
                begin
                    cur[j] = one[j-1];
                    continue;
                end
                best = COST_MAX;
                if (ops_mask[OP_DEL] && bump(one[j]) < best)
                    best = bump(one[j]);
                if (ops_mask[OP_INS] && bump(cur[j-1]) < best)
                    best = bump(cur[j-1]);
                if (ops_mask[OP_SUB] && bump(one[j-1]) < best)
                    best = bump(one[j-1]);
                if (ops_mask[OP_TRA] && i > 1 && j > 1 && r[i-1] == c[j-2]
                    && r[i-2] == c[j-1] && bump(two[j-2]) < best)
                    best = bump(two[j-2]);
                cur[j] = best;
            end
        end
        return cur[m];
    endfunction

    // update strings on an accepted transfer, queue a result at end of pair
    task automatic predict_item(pair_item_t it);
        logic [15:0] ra[];
        logic [15:0] rb[];
        dist_result_t res;
        if (it.has)
        begin
            if (!it.sel)
            begin
                if (len_a < MAX_LEN) begin str_a[len_a] = it.sym; len_a++; end
                else ovf_seen = 1'b1;
            end
            else
            begin
                if (len_b < MAX_LEN) begin str_b[len_b] = it.sym; len_b++; end
                else ovf_seen = 1'b1;
            end
        end
        if (it.last)
        begin
            ra = new[len_a];
            rb = new[len_b];
            for (int k = 0; k < len_a; k++) ra[k] = str_a[k];
            for (int k = 0; k < len_b; k++) rb[k] = str_b[k];
            res.distance = (len_b < len_a) ? osa_distance(rb, ra) : osa_distance(ra, rb);
            res.close = (res.distance <= close_limit);
            res.ovf = ovf_seen;
            expected_dists.insert(expected_dists.size(), res);
            len_a = 0;
            len_b = 0;
            ovf_seen = 1'b0;
        end
    endtask

    // driver: one transfer per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_item('{s_tuser[0], s_tuser[1], s_tlast, s_tdata});
            if ((!s_tvalid || s_tready) )
            begin
                if (pending_items.size() > 0 && !hold_sender
                    && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    pair_item_t it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.sym;
                    s_tuser  <= {it.has, it.sel};
                    s_tlast  <= it.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_dists.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $realtime, m_tdata);
                    error_count++;
                end
                else
                begin
                    dist_result_t e;
                    e = expected_dists.pop_front();
                    if (m_tdata[9:0] !== e.distance || m_tdata[10] !== e.close
                        || m_tdata[11] !== e.ovf)
                    begin
                        $display("%0t: mismatch expected dist %0d close %0b ovf %0b",
                                 $realtime, e.distance, e.close, e.ovf,
                                 ", actual dist %0d close %0b ovf %0b",
                                 m_tdata[9:0], m_tdata[10], m_tdata[11]);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycle_count > 3000000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // append to the pending items
    function automatic void queue_item(pair_item_t it);
        pending_items.insert(pending_items.size(), it);
        queued_count++;
    endfunction

    task automatic add_sym(logic sel, logic [15:0] sym, logic last);
        queue_item('{sel, 1'b1, last, sym});
    endtask

    task automatic add_close();
        queue_item('{1'($urandom_range(1, 0)), 1'b0, 1'b1, 16'($urandom)});
    endtask

    // random pair from a small alphabet so matches and crossings are common
    task automatic add_random_pair(int max_len);
        int la;
        int lb;
        int alpha;
        logic [15:0] base;
        alpha = $urandom_range(4, 1);
        base = 16'($urandom);
        la = $urandom_range(max_len, 0);
        lb = $urandom_range(max_len, 0);
        for (int k = 0; k < la || k < lb; k++)
        begin
            if (k < la) add_sym(1'b0, base ^ 16'($urandom_range(alpha, 0)), 1'b0);
            if (k < lb) add_sym(1'b1, base ^ 16'($urandom_range(alpha, 0)), 1'b0);
            if ($urandom_range(19, 0) == 0)
                queue_item('{1'($urandom_range(1, 0)), 1'b0, 1'b0, 16'($urandom)});
        end
        if ($urandom_range(1, 0)) add_close();
        else queue_item('{1'($urandom_range(1, 0)), 1'b1, 1'b1,
                          base ^ 16'($urandom_range(alpha, 0))});
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_dists.size() > 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_OPS) ops_mask = val[3:0];
        else close_limit = val;
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_OPS;
        cfg_wdata = '0;
        ops_mask = 4'd15;
        close_limit = 10'd3;
        hold_sender = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 46;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pair, empty row string, extremes, transposition
        add_close();
        add_sym(1'b1, 16'hffff, 1'b0);
        add_sym(1'b1, 16'h0000, 1'b0);
        add_close();
        add_sym(1'b0, 16'h0000, 1'b0);
        add_sym(1'b1, 16'hffff, 1'b1);
        add_sym(1'b0, 16'h0001, 1'b0);
        add_sym(1'b0, 16'h0002, 1'b0);
        add_sym(1'b1, 16'h0002, 1'b0);
        add_sym(1'b1, 16'h0001, 1'b1);
        add_sym(1'b0, 16'habcd, 1'b0);
        add_sym(1'b1, 16'habcd, 1'b1);
        add_sym(1'b0, 16'h5a5a, 1'b0);
        add_sym(1'b0, 16'ha5a5, 1'b0);
        add_sym(1'b1, 16'h5a5a, 1'b1);
        wait_drained();

        // overflow of the first string, then the sender pauses until every
        // outstanding result is back
        for (int k = 0; k < MAX_LEN + 2; k++)
            add_sym(1'b0, 16'($urandom_range(1, 0)), 1'b0);
        add_sym(1'b1, 16'h0001, 1'b1);
        add_sym(1'b0, 16'h0003, 1'b0);
        add_sym(1'b1, 16'h0004, 1'b1);
        while (expected_dists.size() == 0)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_dists.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        // phases over the mask and threshold, extremes included
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_OPS, 10'd0); write_reg(REG_THR, 10'd0); end
                1: begin write_reg(REG_OPS, 10'd15); write_reg(REG_THR, 10'd1023); end
                2: begin write_reg(REG_OPS, 10'd3); write_reg(REG_THR, 10'd2); end
                3: begin write_reg(REG_OPS, 10'd4); write_reg(REG_THR, 10'd5); end
                4: begin write_reg(REG_OPS, 10'd8); write_reg(REG_THR, 10'd3); end
                default: begin
                    write_reg(REG_OPS, 10'($urandom_range(15, 0)));
                    write_reg(REG_THR, 10'($urandom_range(12, 0)));
                end
            endcase
            if (ph == 3) begin send_idle_pct = 46; recv_idle_pct = 13; end
            if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int p = 0; p < 10; p++)
                add_random_pair((p == 9 && ph == 8) ? 40 : 9);
            wait_drained();
        end
        while (queued_count < 1300)
            add_random_pair(8);
        wait_drained();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
